// ===== rtl/core/fct_pkg.sv =====
// fct_pkg: shared widths, plane and vector types, and status codes for the
// frustum culling test. No dependencies.

package fct_pkg;

    localparam int COORD_WIDTH = 16;                       // signed coordinate width
    localparam int NUM_PLANES  = 6;
    localparam int FIELD_W     = 16;                       // plane fields and input fields
    localparam int NORM_FRAC   = 14;                       // Q1.14 normal fraction bits
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4 * FIELD_W;
    localparam int PROD_W      = FIELD_W + COORD_WIDTH;
    localparam int D_SHIFT_W   = FIELD_W + NORM_FRAC;
    localparam int DIST_W      = ((PROD_W > D_SHIFT_W) ? PROD_W : D_SHIFT_W) + 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [FIELD_W-1:0]     t_field;
    typedef logic signed [PROD_W-1:0]      t_prod;

    // packed so that nx sits in bits 15:0 and d in bits 63:48
    typedef struct packed {
        t_field d;
        t_field nz;
        t_field ny;
        t_field nx;
    } t_plane;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec3;

    typedef struct packed {
        t_prod  px;
        t_prod  py;
        t_prod  pz;
        t_field d;
    } t_plane_terms;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FRUSTUM_BAD = 2'd1,
        ST_BOX_BAD     = 2'd2
    } t_status;

    typedef enum logic {
        MODE_POINT = 1'b0,
        MODE_BOX   = 1'b1
    } t_mode;

endpackage

// ===== rtl/core/fct_if.sv =====
// fct_if: valid/ready channel interfaces for the frustum culling test
// (request, result and configuration write). Depends on fct_pkg.

interface fct_req_if import fct_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   mode;
    t_field min_x;
    t_field min_y;
    t_field min_z;
    t_field max_x;
    t_field max_y;
    t_field max_z;

    modport source (output valid, mode, min_x, min_y, min_z, max_x, max_y, max_z,
                    input ready);
    modport sink   (input valid, mode, min_x, min_y, min_z, max_x, max_y, max_z,
                    output ready);
endinterface

interface fct_res_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [1:0] status;

    modport source (output valid, visible, status, input ready);
    modport sink   (input valid, visible, status, output ready);
endinterface

interface fct_cfg_if import fct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fct_plane_terms.sv =====
// fct_plane_terms: picks the test corner for one plane and forms the three
// normal-by-coordinate products. Depends on fct_pkg.

module fct_plane_terms import fct_pkg::*; (
    input  t_plane       i_plane,
    input  logic         i_mode,
    input  t_vec3        i_lo,
    input  t_vec3        i_hi,
    output t_plane_terms o_terms
);

    t_coord cx, cy, cz;
    t_prod  nx_w, ny_w, nz_w;
    t_prod  cx_w, cy_w, cz_w;

    // box mode tests the corner furthest along the normal; zero picks max
    always_comb begin
        cx = (i_mode == MODE_BOX && !i_plane.nx[FIELD_W-1]) ? i_hi.x : i_lo.x;
        cy = (i_mode == MODE_BOX && !i_plane.ny[FIELD_W-1]) ? i_hi.y : i_lo.y;
        cz = (i_mode == MODE_BOX && !i_plane.nz[FIELD_W-1]) ? i_hi.z : i_lo.z;
        nx_w = PROD_W'(i_plane.nx);
        ny_w = PROD_W'(i_plane.ny);
        nz_w = PROD_W'(i_plane.nz);
        cx_w = PROD_W'(cx);
        cy_w = PROD_W'(cy);
        cz_w = PROD_W'(cz);
        o_terms.px = nx_w * cx_w;
        o_terms.py = ny_w * cy_w;
        o_terms.pz = nz_w * cz_w;
        o_terms.d  = i_plane.d;
    end

endmodule

// ===== rtl/core/frustum_cull_test.sv =====
// frustum_cull_test: six-plane point / box frustum test, top level.
// Depends on fct_pkg, fct_if and fct_plane_terms.

// One request per clock while o_res.ready holds; a request passes through an input
// register, a product register holding the eighteen 16x16 normal-by-corner
// products, and the result register after the per-plane sum and sign test.
// Each stage advances when the stage after it is empty or moving, so requests
// keep flowing while a result waits and bubbles are squeezed out; i_req.ready
// follows o_res.ready combinationally through that chain. Plane registers are
// written through i_cfg (index 0..5 left, right, bottom, top, near, far; others
// ignored), always ready, and must only be written while no request is in flight.
// Until all six planes have a nonzero normal every result reports status 1.

module frustum_cull_test import fct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fct_cfg_if.sink   i_cfg,
    fct_req_if.sink   i_req,
    fct_res_if.source o_res
);

    t_plane       r_plane [NUM_PLANES];

    logic         r_s1_valid;
    logic         r_s1_mode;
    t_vec3        r_s1_lo;
    t_vec3        r_s1_hi;

    logic         r_s2_valid;
    t_status      r_s2_status;
    t_plane_terms r_s2_terms [NUM_PLANES];

    logic         r_out_valid;
    logic         r_out_visible;
    t_status      r_out_status;

    logic         out_adv;
    logic         s2_adv;
    logic         s1_adv;
    logic         frustum_ok;
    logic         box_bad;
    t_status      n_s2_status;
    t_plane_terms terms [NUM_PLANES];
    logic         [NUM_PLANES-1:0] plane_neg;
    logic         n_out_visible;

    assign out_adv = !r_out_valid || o_res.ready;
    assign s2_adv  = !r_s2_valid || out_adv;
    assign s1_adv  = !r_s1_valid || s2_adv;

    assign i_req.ready = s1_adv;
    assign i_cfg.ready = 1'b1;

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.index < CFG_IDX_W'(NUM_PLANES)) begin
            r_plane[i_cfg.index] <= t_plane'(i_cfg.data);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_req.valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // stage 1: request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && s1_adv) begin
            r_s1_mode <= i_req.mode;
            r_s1_lo   <= '{x: t_coord'(i_req.min_x), y: t_coord'(i_req.min_y),
                           z: t_coord'(i_req.min_z)};
            r_s1_hi   <= '{x: t_coord'(i_req.max_x), y: t_coord'(i_req.max_y),
                           z: t_coord'(i_req.max_z)};
        end
    end

    // stage 1 -> 2: validity checks and products
    always_comb begin
        frustum_ok = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            if (r_plane[i].nx == '0 && r_plane[i].ny == '0 && r_plane[i].nz == '0) begin
                frustum_ok = 1'b0;
            end
        end
        box_bad = (r_s1_mode == MODE_BOX) &&
                  (r_s1_lo.x > r_s1_hi.x || r_s1_lo.y > r_s1_hi.y || r_s1_lo.z > r_s1_hi.z);
        if (!frustum_ok) begin
            n_s2_status = ST_FRUSTUM_BAD;
        end else if (box_bad) begin
            n_s2_status = ST_BOX_BAD;
        end else begin
            n_s2_status = ST_OK;
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        fct_plane_terms u_terms (
            .i_plane (r_plane[g]),
            .i_mode  (r_s1_mode),
            .i_lo    (r_s1_lo),
            .i_hi    (r_s1_hi),
            .o_terms (terms[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_adv) begin
            r_s2_status <= n_s2_status;
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_s2_terms[i] <= terms[i];
            end
        end
    end

    // stage 2 -> out: exact signed distance per plane, sign test
    always_comb begin
        logic signed [DIST_W-1:0] plane_sum;
        for (int i = 0; i < NUM_PLANES; i++) begin
            plane_sum = DIST_W'(r_s2_terms[i].px) + DIST_W'(r_s2_terms[i].py)
                      + DIST_W'(r_s2_terms[i].pz) + (DIST_W'(r_s2_terms[i].d) <<< NORM_FRAC);
            plane_neg[i] = plane_sum[DIST_W-1];
        end
        n_out_visible = (r_s2_status == ST_OK) && (plane_neg == '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && out_adv) begin
            r_out_visible <= n_out_visible;
            r_out_status  <= r_s2_status;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.visible = r_out_visible;
    assign o_res.status  = r_out_status;

endmodule

// ===== rtl/core/fct_checker.sv =====
// fct_checker: port-level checks on the frustum culling test results,
// bound to frustum_cull_test. Depends on fct_pkg.

module fct_checker import fct_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_res_visible,
    input logic [1:0] i_res_status
);

    // a result offered and not taken stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_status == ST_OK || i_res_status == ST_FRUSTUM_BAD ||
                         i_res_status == ST_BOX_BAD))
        else $error("status code out of range");

    // any failure status forces not visible
    a_fail_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status != ST_OK |-> !i_res_visible)
        else $error("visible set with failure status");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_visible (o_res.visible),
    .i_res_status  (o_res.status)
);
